// File: sv/julia_escape_time_macros.svh
// Assertion helpers used by the checker file jet_chk.sv.
`ifndef JULIA_ESCAPE_TIME_MACROS_SVH
`define JULIA_ESCAPE_TIME_MACROS_SVH

// Checked only while out of reset.
`define JET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define JET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/jet_pkg.sv
`default_nettype none
package jet_pkg;

    localparam int DATA_W    = 32;
    localparam int STEP_W    = 29;
    localparam int PIX_W     = 10;
    localparam int ITER_W    = 10;
    localparam int WIDE_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 28;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [STEP_W-1:0] STEP_X_RST   = STEP_W'(786432);
    localparam logic [STEP_W-1:0] STEP_Y_RST   = STEP_W'(524288);
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL   = 3'd0,
        CFG_C_IMAG   = 3'd1,
        CFG_OFFSET_X = 3'd2,
        CFG_OFFSET_Y = 3'd3,
        CFG_STEP_X   = 3'd4,
        CFG_STEP_Y   = 3'd5,
        CFG_MAX_ITER = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
        logic signed [DATA_W-1:0] offset_x;
        logic signed [DATA_W-1:0] offset_y;
        logic [STEP_W-1:0]        step_x;
        logic [STEP_W-1:0]        step_y;
        logic [ITER_W-1:0]        max_iter;
    } t_cfg;

    // one mapped pixel waiting for the iteration engine
    typedef struct packed {
        logic [PIX_W-1:0]         px;
        logic [PIX_W-1:0]         py;
        logic signed [DATA_W-1:0] zr;
        logic signed [DATA_W-1:0] zi;
    } t_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_EVAL
    } t_back_state;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: sv/jet_front.sv
`default_nettype none
module jet_front #(
    parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [jet_pkg::PIX_W-1:0]     i_pixel_x,
    input  wire logic [jet_pkg::PIX_W-1:0]     i_pixel_y,
    input  wire jet_pkg::t_cfg                 i_cfg,
    input  wire logic [jet_pkg::Q_CNT_W-1:0]   i_q_count,
    output logic                               o_busy,
    output logic                               o_push,
    output jet_pkg::t_item                     o_item
);

    localparam int MAP_W = jet_pkg::PIX_W + 1 + jet_pkg::STEP_W + 1;
    localparam logic signed [jet_pkg::PIX_W:0] HALF_X = (jet_pkg::PIX_W + 1)'(IMAGE_WIDTH / 2);
    localparam logic signed [jet_pkg::PIX_W:0] HALF_Y = (jet_pkg::PIX_W + 1)'(IMAGE_HEIGHT / 2);

    logic                            r_vld;
    logic [jet_pkg::PIX_W-1:0]       r_px;
    logic [jet_pkg::PIX_W-1:0]       r_py;
    logic signed [MAP_W-1:0]         r_prod_x;
    logic signed [MAP_W-1:0]         r_prod_y;

    logic                            w_accept;
    logic signed [jet_pkg::PIX_W:0]  w_dx;
    logic signed [jet_pkg::PIX_W:0]  w_dy;
    logic signed [MAP_W-1:0]         w_prod_x;
    logic signed [MAP_W-1:0]         w_prod_y;
    logic signed [jet_pkg::WIDE_W-1:0] w_sum_x;
    logic signed [jet_pkg::WIDE_W-1:0] w_sum_y;

    // room must exist for the item in flight here plus the new one
    assign o_busy   = ({1'b0, i_q_count} + (jet_pkg::Q_CNT_W + 1)'(r_vld))
                      >= (jet_pkg::Q_CNT_W + 1)'(jet_pkg::Q_DEPTH);
    assign w_accept = i_start && !o_busy;

    assign w_dx     = $signed({1'b0, i_pixel_x}) - HALF_X;
    assign w_dy     = $signed({1'b0, i_pixel_y}) - HALF_Y;
    assign w_prod_x = w_dx * $signed({1'b0, i_cfg.step_x});
    assign w_prod_y = w_dy * $signed({1'b0, i_cfg.step_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_accept;
        end
        if (w_accept) begin
            r_px     <= i_pixel_x;
            r_py     <= i_pixel_y;
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
    end

    assign w_sum_x = jet_pkg::WIDE_W'(r_prod_x) + jet_pkg::WIDE_W'(i_cfg.offset_x);
    assign w_sum_y = jet_pkg::WIDE_W'(r_prod_y) + jet_pkg::WIDE_W'(i_cfg.offset_y);

    assign o_push    = r_vld;
    assign o_item.px = r_px;
    assign o_item.py = r_py;
    assign o_item.zr = jet_pkg::sat_data(w_sum_x);
    assign o_item.zi = jet_pkg::sat_data(w_sum_y);

endmodule
`default_nettype wire

// File: sv/jet_queue.sv
`default_nettype none
module jet_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire jet_pkg::t_item              i_item,
    input  wire logic                        i_pop,
    output jet_pkg::t_item                   o_item,
    output logic                             o_empty,
    output logic [jet_pkg::Q_CNT_W-1:0]      o_count
);

    localparam logic [jet_pkg::Q_PTR_W-1:0] LAST = jet_pkg::Q_PTR_W'(jet_pkg::Q_DEPTH - 1);

    jet_pkg::t_item                  r_mem [jet_pkg::Q_DEPTH];
    logic [jet_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [jet_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [jet_pkg::Q_CNT_W-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

// File: sv/jet_back.sv
`default_nettype none
module jet_back #(
    parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire jet_pkg::t_cfg              i_cfg,
    input  wire jet_pkg::t_item             i_item,
    input  wire logic                       i_q_empty,
    output logic                            o_pop,
    output logic                            o_strobe,
    output logic [jet_pkg::PIX_W-1:0]       o_out_x,
    output logic [jet_pkg::PIX_W-1:0]       o_out_y,
    output logic [jet_pkg::ITER_W-1:0]      o_iter_count
);

    localparam int W = jet_pkg::WIDE_W;
    localparam logic [W-1:0] LIMIT = W'(1) << (2 * FRAC_BITS + 2);

    jet_pkg::t_back_state r_state, n_state;
    logic signed [jet_pkg::DATA_W-1:0] r_zr, n_zr;
    logic signed [jet_pkg::DATA_W-1:0] r_zi, n_zi;
    logic signed [W-1:0]               r_rr, n_rr;
    logic signed [W-1:0]               r_ii, n_ii;
    logic signed [W-1:0]               r_ri, n_ri;
    logic [jet_pkg::ITER_W-1:0]        r_cnt, n_cnt;
    logic                              r_fresh, n_fresh;
    logic [jet_pkg::PIX_W-1:0]         r_px, n_px;
    logic [jet_pkg::PIX_W-1:0]         r_py, n_py;
    logic                              r_strobe, n_strobe;
    logic [jet_pkg::PIX_W-1:0]         r_out_x, n_out_x;
    logic [jet_pkg::PIX_W-1:0]         r_out_y, n_out_y;
    logic [jet_pkg::ITER_W-1:0]        r_out_cnt, n_out_cnt;

    logic [W-1:0]                      w_mag;
    logic signed [W-1:0]               w_re_sum;
    logic signed [W-1:0]               w_im_sum;
    logic signed [jet_pkg::DATA_W-1:0] w_new_zr;
    logic signed [jet_pkg::DATA_W-1:0] w_new_zi;
    logic [jet_pkg::ITER_W-1:0]        w_cnt_inc;
    logic                              w_escaped;

    // c is folded in before the floor shift: floor((a + c*2^s)/2^s) = floor(a/2^s) + c
    assign w_re_sum  = r_rr - r_ii + (W'(i_cfg.c_real) <<< FRAC_BITS);
    assign w_im_sum  = r_ri + (W'(i_cfg.c_imag) <<< (FRAC_BITS - 1));
    assign w_new_zr  = jet_pkg::sat_data(w_re_sum >>> FRAC_BITS);
    assign w_new_zi  = jet_pkg::sat_data(w_im_sum >>> (FRAC_BITS - 1));
    assign w_mag     = $unsigned(r_rr) + $unsigned(r_ii);
    // products in r_rr/r_ii belong to the z just produced, except on the first pass
    assign w_escaped = !r_fresh && (w_mag > LIMIT);
    assign w_cnt_inc = r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= jet_pkg::BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_zr      <= n_zr;
        r_zi      <= n_zi;
        r_rr      <= n_rr;
        r_ii      <= n_ii;
        r_ri      <= n_ri;
        r_cnt     <= n_cnt;
        r_fresh   <= n_fresh;
        r_px      <= n_px;
        r_py      <= n_py;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_cnt <= n_out_cnt;
    end

    always_comb begin
        n_state   = r_state;
        n_zr      = r_zr;
        n_zi      = r_zi;
        n_rr      = r_rr;
        n_ii      = r_ii;
        n_ri      = r_ri;
        n_cnt     = r_cnt;
        n_fresh   = r_fresh;
        n_px      = r_px;
        n_py      = r_py;
        n_strobe  = 1'b0;
        n_out_x   = r_out_x;
        n_out_y   = r_out_y;
        n_out_cnt = r_out_cnt;
        o_pop     = 1'b0;
        case (r_state)
            jet_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_zr    = i_item.zr;
                    n_zi    = i_item.zi;
                    n_px    = i_item.px;
                    n_py    = i_item.py;
                    n_cnt   = '0;
                    n_fresh = 1'b1;
                    if (i_cfg.max_iter == '0) begin
                        n_strobe  = 1'b1;
                        n_out_x   = i_item.px;
                        n_out_y   = i_item.py;
                        n_out_cnt = '0;
                    end else begin
                        n_state = jet_pkg::BK_MUL;
                    end
                end
            end
            jet_pkg::BK_MUL: begin
                n_rr    = r_zr * r_zr;
                n_ii    = r_zi * r_zi;
                n_ri    = r_zr * r_zi;
                n_state = jet_pkg::BK_EVAL;
            end
            jet_pkg::BK_EVAL: begin
                if (w_escaped) begin
                    n_strobe  = 1'b1;
                    n_out_x   = r_px;
                    n_out_y   = r_py;
                    n_out_cnt = r_cnt;
                    n_state   = jet_pkg::BK_IDLE;
                end else if (!r_fresh && (w_cnt_inc == i_cfg.max_iter)) begin
                    n_strobe  = 1'b1;
                    n_out_x   = r_px;
                    n_out_y   = r_py;
                    n_out_cnt = w_cnt_inc;
                    n_state   = jet_pkg::BK_IDLE;
                end else begin
                    n_cnt   = r_fresh ? r_cnt : w_cnt_inc;
                    n_zr    = w_new_zr;
                    n_zi    = w_new_zi;
                    n_fresh = 1'b0;
                    n_state = jet_pkg::BK_MUL;
                end
            end
            default: begin
                n_state = jet_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_iter_count = r_out_cnt;

endmodule
`default_nettype wire

// File: sv/julia_escape_time.sv
`default_nettype none
// Julia set escape-time engine, one pixel per item.
// Input: an item (i_pixel_x, i_pixel_y) is taken at a clock edge with start high and
// busy low. The mapper multiplies on that edge, adds the offset and pushes the start
// point into a two-entry queue in the next cycle; busy is high while the mapper and the
// queue hold two items between them.
// Output: o_strobe is high for one cycle with o_out_x, o_out_y, o_iter_count. The
// receiver cannot stall; results leave in the order items were taken.
// Engine: the iteration engine pops one item at a time from the queue. Each iteration
// passes through a multiply state (three 32x32 multipliers) and an evaluate state (the
// update and the |z|^2 test). The mapper and queue still take new items while the
// engine works on an earlier one, until busy rises.
// Configuration: i_cfg_we writes register i_cfg_idx (0 c_real, 1 c_imag, 2 offset_x,
// 3 offset_y, 4 step_x, 5 step_y, 6 max_iter) at once; other indexes are ignored.
// Write only while no item is in flight.
// Reset (i_rst_n low, synchronous) empties the queue, drops any item in progress and
// restores the register defaults.
module julia_escape_time #(
    parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF,
    parameter int FRAC_BITS    = jet_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [jet_pkg::PIX_W-1:0]       i_pixel_x,
    input  wire logic [jet_pkg::PIX_W-1:0]       i_pixel_y,
    output logic                                 o_strobe,
    output logic [jet_pkg::PIX_W-1:0]            o_out_x,
    output logic [jet_pkg::PIX_W-1:0]            o_out_y,
    output logic [jet_pkg::ITER_W-1:0]           o_iter_count,
    input  wire logic                            i_cfg_we,
    input  wire logic [jet_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [jet_pkg::DATA_W-1:0]      i_cfg_data
);

    jet_pkg::t_cfg                r_cfg;
    jet_pkg::t_item               w_push_item;
    jet_pkg::t_item               w_head_item;
    logic                         w_push;
    logic                         w_pop;
    logic                         w_q_empty;
    logic [jet_pkg::Q_CNT_W-1:0]  w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c_real   <= '0;
            r_cfg.c_imag   <= '0;
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
            r_cfg.step_x   <= jet_pkg::STEP_X_RST;
            r_cfg.step_y   <= jet_pkg::STEP_Y_RST;
            r_cfg.max_iter <= jet_pkg::MAX_ITER_RST;
        end else if (i_cfg_we) begin
            case (jet_pkg::t_cfg_idx'(i_cfg_idx))
                jet_pkg::CFG_C_REAL:   r_cfg.c_real   <= i_cfg_data;
                jet_pkg::CFG_C_IMAG:   r_cfg.c_imag   <= i_cfg_data;
                jet_pkg::CFG_OFFSET_X: r_cfg.offset_x <= i_cfg_data;
                jet_pkg::CFG_OFFSET_Y: r_cfg.offset_y <= i_cfg_data;
                jet_pkg::CFG_STEP_X:   r_cfg.step_x   <= i_cfg_data[jet_pkg::STEP_W-1:0];
                jet_pkg::CFG_STEP_Y:   r_cfg.step_y   <= i_cfg_data[jet_pkg::STEP_W-1:0];
                jet_pkg::CFG_MAX_ITER: r_cfg.max_iter <= i_cfg_data[jet_pkg::ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jet_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (r_cfg),
        .i_q_count (w_q_count),
        .o_busy    (busy),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    jet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    jet_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (w_head_item),
        .i_q_empty    (w_q_empty),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_iter_count (o_iter_count)
    );

endmodule
`default_nettype wire

// File: sv/jet_chk.sv
`default_nettype none
`include "julia_escape_time_macros.svh"
module jet_chk (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            o_strobe,
    input  wire logic [jet_pkg::ITER_W-1:0]      o_iter_count,
    input  wire logic                            i_cfg_we,
    input  wire logic [jet_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [jet_pkg::DATA_W-1:0]      i_cfg_data
);

    // shadow of the iteration limit as seen on the config port
    logic [jet_pkg::ITER_W-1:0] r_max_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= jet_pkg::MAX_ITER_RST;
        end else if (i_cfg_we && (i_cfg_idx == jet_pkg::CFG_MAX_ITER)) begin
            r_max_iter <= i_cfg_data[jet_pkg::ITER_W-1:0];
        end
    end

    `JET_ASSERT_ALWAYS(a_no_strobe_after_reset, !i_rst_n |=> !o_strobe, "result strobe right after reset")
    `JET_ASSERT(a_count_within_limit, o_strobe |-> (o_iter_count <= r_max_iter), "iteration count above limit")
    `JET_ASSERT(a_busy_needs_accept, $rose(busy) |-> $past(start), "busy rose without an accepted item")

endmodule

bind julia_escape_time jet_chk u_jet_chk (.*);
`default_nettype wire

// File: bench/tb_julia_escape_time.sv
`default_nettype none
module tb_julia_escape_time;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     Q_ONE     = 1 << jet_pkg::FRAC_BITS_DEF;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam logic [63:0] ESC_LIM = 64'd4 << (2 * jet_pkg::FRAC_BITS_DEF);
    localparam int     RAND_ITEMS = 1600;
    localparam int     MAX_SHOWN  = 10;
    localparam logic [jet_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum logic {ROW_PIX, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [jet_pkg::CFG_IDX_W-1:0]   idx;
        logic [jet_pkg::DATA_W-1:0]      data;
        logic [jet_pkg::PIX_W-1:0]       px;
        logic [jet_pkg::PIX_W-1:0]       py;
        logic                            known;
        logic [jet_pkg::ITER_W-1:0]      iter;
    } t_dir_row;

    typedef struct packed {
        logic [jet_pkg::PIX_W-1:0]  px;
        logic [jet_pkg::PIX_W-1:0]  py;
        logic [jet_pkg::ITER_W-1:0] iter;
    } t_pix_result;

    localparam int NDIR = 44;
    // known iteration counts are the ones obvious from the window and constant
    localparam t_dir_row DIR_TAB [NDIR] = '{
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd256},
        '{ROW_PIX, '0, '0, 10'd0, 10'd0, 1'b1, 10'd0},
        '{ROW_PIX, '0, '0, 10'd1023, 10'd1023, 1'b1, 10'd0},
        '{ROW_PIX, '0, '0, 10'd1023, 10'd0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd0, 10'd1023, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd600, 10'd400, 1'b0, '0},
        '{ROW_CFG, CFG_UNUSED_IDX, 32'd1, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd256},
        '{ROW_CFG, jet_pkg::CFG_MAX_ITER, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd0},
        '{ROW_PIX, '0, '0, 10'd0, 10'd1023, 1'b1, 10'd0},
        '{ROW_CFG, jet_pkg::CFG_MAX_ITER, 32'd1, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd1},
        '{ROW_PIX, '0, '0, 10'd0, 10'd0, 1'b1, 10'd0},
        '{ROW_CFG, jet_pkg::CFG_MAX_ITER, 32'd1023, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd1023},
        '{ROW_PIX, '0, '0, 10'd520, 10'd515, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_MAX_ITER, 32'd64, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_C_REAL, 32'h8000_0000, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd0},
        '{ROW_CFG, jet_pkg::CFG_C_REAL, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_C_IMAG, 32'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd0},
        // c = -0.8 + 0.156i
        '{ROW_CFG, jet_pkg::CFG_C_REAL, 32'hF333_3333, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_C_IMAG, 32'd41875931, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd300, 10'd700, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd700, 10'd300, 1'b0, '0},
        // mapping saturates at both ends
        '{ROW_CFG, jet_pkg::CFG_OFFSET_X, 32'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_OFFSET_Y, 32'h8000_0000, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_STEP_X, 32'd268435456, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_STEP_Y, 32'd268435456, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd1023, 10'd0, 1'b1, 10'd0},
        '{ROW_PIX, '0, '0, 10'd0, 10'd1023, 1'b1, 10'd0},
        '{ROW_CFG, jet_pkg::CFG_STEP_X, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_STEP_Y, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_OFFSET_X, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_OFFSET_Y, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd0, 10'd0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd1023, 10'd1023, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_C_REAL, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_C_IMAG, 32'd0, '0, '0, 1'b0, '0},
        '{ROW_CFG, jet_pkg::CFG_OFFSET_X, 32'h8000_0000, '0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, 10'd512, 10'd512, 1'b1, 10'd0}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [jet_pkg::PIX_W-1:0]      i_pixel_x;
    logic [jet_pkg::PIX_W-1:0]      i_pixel_y;
    logic                           o_strobe;
    logic [jet_pkg::PIX_W-1:0]      o_out_x;
    logic [jet_pkg::PIX_W-1:0]      o_out_y;
    logic [jet_pkg::ITER_W-1:0]     o_iter_count;
    logic                           i_cfg_we;
    logic [jet_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [jet_pkg::DATA_W-1:0]     i_cfg_data;

    julia_escape_time dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_strobe     (o_strobe),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_iter_count (o_iter_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // register mirror used by the predictor
    logic signed [jet_pkg::DATA_W-1:0] jc_re, jc_im, pan_x, pan_y;
    logic [jet_pkg::STEP_W-1:0]        step_x_q, step_y_q;
    logic [jet_pkg::ITER_W-1:0]        iter_limit;

    t_pix_result pending_pixels[$];
    int     n_items, n_results, n_errors, n_phases;
    longint cycle_cnt, budget;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint clamp32(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint map_axis(input logic [jet_pkg::PIX_W-1:0] pix, input int size,
                                        input logic [jet_pkg::STEP_W-1:0] step,
                                        input logic signed [jet_pkg::DATA_W-1:0] pan);
        longint d;
        d = longint'(pix) - longint'(size / 2);
        return clamp32(d * longint'(step) + longint'(pan));
    endfunction

    function automatic logic [jet_pkg::ITER_W-1:0] escape_count(
        input logic [jet_pkg::PIX_W-1:0] px,
        input logic [jet_pkg::PIX_W-1:0] py);
        longint      zr, zi, nr, ni;
        logic [63:0] rr2, ii2;
        int unsigned n;
        zr = map_axis(px, jet_pkg::IMAGE_WIDTH_DEF, step_x_q, pan_x);
        zi = map_axis(py, jet_pkg::IMAGE_HEIGHT_DEF, step_y_q, pan_y);
        n = 0;
        while (n < iter_limit) begin
            nr = clamp32(((zr * zr - zi * zi) >>> jet_pkg::FRAC_BITS_DEF) + longint'(jc_re));
            ni = clamp32(((zr * zi) >>> (jet_pkg::FRAC_BITS_DEF - 1)) + longint'(jc_im));
            zr = nr;
            zi = ni;
            rr2 = zr * zr;
            ii2 = zi * zi;
            if (rr2 + ii2 > ESC_LIM) break;
            n++;
        end
        return n[jet_pkg::ITER_W-1:0];
    endfunction

    function automatic logic [jet_pkg::DATA_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(input string what);
        n_errors++;
        if (n_errors <= MAX_SHOWN) $display("MISMATCH: %s", what);
    endtask

    task automatic write_reg(input logic [jet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jet_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            jet_pkg::CFG_C_REAL:   jc_re = data;
            jet_pkg::CFG_C_IMAG:   jc_im = data;
            jet_pkg::CFG_OFFSET_X: pan_x = data;
            jet_pkg::CFG_OFFSET_Y: pan_y = data;
            jet_pkg::CFG_STEP_X:   step_x_q = data[jet_pkg::STEP_W-1:0];
            jet_pkg::CFG_STEP_Y:   step_y_q = data[jet_pkg::STEP_W-1:0];
            jet_pkg::CFG_MAX_ITER: iter_limit = data[jet_pkg::ITER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        budget += 4;
    endtask

    // hold off the sender until every item has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        budget += 16;
    endtask

    task automatic send_pixel(input logic [jet_pkg::PIX_W-1:0] px,
                              input logic [jet_pkg::PIX_W-1:0] py,
                              input logic known, input logic [jet_pkg::ITER_W-1:0] iter,
                              input bit calm);
        int          gap, r;
        t_pix_result exp_res;
        r = $urandom_range(0, 99);
        if (calm || r < 55) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 4);
        else gap = $urandom_range(10, 150);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_pixel_x = px;
        i_pixel_y = py;
        do @(posedge i_clk); while (busy);
        exp_res.px   = px;
        exp_res.py   = py;
        exp_res.iter = known ? iter : escape_count(px, py);
        pending_pixels.push_back(exp_res);
        n_items++;
        budget += longint'(gap) + 2 * longint'(iter_limit) + 16;
    endtask

    always @(posedge i_clk) begin : check_results
        t_pix_result e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected result x=%0d y=%0d n=%0d",
                                 o_out_x, o_out_y, o_iter_count));
            end else begin
                e = pending_pixels.pop_front();
                if (o_out_x !== e.px || o_out_y !== e.py || o_iter_count !== e.iter) begin
                    report($sformatf("expected x=%0d y=%0d n=%0d, got x=%0d y=%0d n=%0d",
                                     e.px, e.py, e.iter, o_out_x, o_out_y, o_iter_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 4 * budget + 100000) begin
            $display("tb_julia_escape_time failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row                   row;
        int                         rand_items, phase_items, kind;
        bit                         calm;
        logic [jet_pkg::DATA_W-1:0] cr, ci, ox, oy, sx, sy, mi;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_pixel_x  = '0;
        i_pixel_y  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = jet_pkg::CFG_C_REAL;
        i_cfg_data = '0;
        jc_re      = '0;
        jc_im      = '0;
        pan_x      = '0;
        pan_y      = '0;
        step_x_q   = jet_pkg::STEP_X_RST;
        step_y_q   = jet_pkg::STEP_Y_RST;
        iter_limit = jet_pkg::MAX_ITER_RST;
        n_items    = 0;
        n_results  = 0;
        n_errors   = 0;
        n_phases   = 0;
        cycle_cnt  = 0;
        budget     = 0;
        rand_items = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NDIR; r++) begin
            row = DIR_TAB[r];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_reg(row.idx, row.data);
            end else begin
                send_pixel(row.px, row.py, row.known, row.iter, 1'b0);
            end
        end

        while (rand_items < RAND_ITEMS) begin
            phase_items = 100;
            calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // window around the set with a classic-range constant
                cr = 32'($urandom_range(0, 3 * Q_ONE / 2)) - 32'(Q_ONE);
                ci = 32'($urandom_range(0, 2 * Q_ONE)) - 32'(Q_ONE);
                ox = 32'($urandom_range(0, Q_ONE)) - 32'(Q_ONE / 2);
                oy = 32'($urandom_range(0, Q_ONE)) - 32'(Q_ONE / 2);
                sx = $urandom_range(1 << 12, 1 << 20);
                sy = $urandom_range(1 << 12, 1 << 20);
                mi = $urandom_range(1, 64);
            end else if (kind == 7) begin
                cr = extreme_word();
                ci = extreme_word();
                ox = extreme_word();
                oy = extreme_word();
                sx = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'(Q_ONE);
                sy = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
                case ($urandom_range(0, 3))
                    0: mi = 32'd0;
                    1: mi = 32'd1;
                    2: mi = 32'd1023;
                    default: mi = $urandom_range(1, 1023);
                endcase
            end else if (kind == 8) begin
                cr = $urandom;
                ci = $urandom;
                ox = $urandom;
                oy = $urandom;
                sx = $urandom;
                sy = $urandom;
                mi = $urandom;
            end else begin
                cr = 32'($urandom_range(0, 3 * Q_ONE / 2)) - 32'(Q_ONE);
                ci = 32'($urandom_range(0, 2 * Q_ONE)) - 32'(Q_ONE);
                ox = '0;
                oy = '0;
                sx = 32'(jet_pkg::STEP_X_RST);
                sy = 32'(jet_pkg::STEP_Y_RST);
                mi = ($urandom_range(0, 3) == 0) ? 32'd1023 : 32'd256;
            end
            wait_drained();
            write_reg(jet_pkg::CFG_C_REAL, cr);
            write_reg(jet_pkg::CFG_C_IMAG, ci);
            write_reg(jet_pkg::CFG_OFFSET_X, ox);
            write_reg(jet_pkg::CFG_OFFSET_Y, oy);
            write_reg(jet_pkg::CFG_STEP_X, sx);
            write_reg(jet_pkg::CFG_STEP_Y, sy);
            write_reg(jet_pkg::CFG_MAX_ITER, mi);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, $urandom);
            if (iter_limit > 256) phase_items = 12;
            for (int k = 0; k < phase_items; k++) begin
                if ($urandom_range(0, 63) == 0) wait_drained();
                send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           1'b0, '0, calm);
                rand_items++;
            end
            n_phases++;
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d pixels (%0d directed rows, %0d random settings), %0d results checked",
                 n_items, NDIR, n_phases, n_results);
        $display("Settings spanned classic windows, saturating pans and constants, limits 0..1023");
        if (n_errors == 0 && pending_pixels.size() == 0) begin
            $display("tb_julia_escape_time passed");
        end else begin
            $display("tb_julia_escape_time failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
